// ----- hdl/olif_pkg.sv -----
// olif_pkg: shared types and codes for the ordered list insert / find unit
// no dependencies; imported by olif_cell, olif_out_fifo and the top level

package olif_pkg;

  // item modes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_FIND   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_BAD_POS = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  // field widths fixed by the item format
  localparam int unsigned POS_W = 5;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W = 4;
  localparam int unsigned LEN_W = 5;

  // search token that walks down the cell chain
  typedef struct packed {
    logic             active;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } probe_t;

  // one result item
  typedef struct packed {
    logic [1:0]       status;
    logic             found;
    logic [IDX_W-1:0] found_index;
    logic [LEN_W-1:0] length;
  } result_t;

  // control sequencer states
  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

endpackage

// ----- hdl/olif_cell.sv -----
// olif_cell: one list slot; holds an entry, shifts on insert, checks the search token
// depends on olif_pkg

module olif_cell import olif_pkg::*; #(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              ins_en,
  input  logic [CNT_W-1:0]  ins_pos,
  input  logic [CNT_W-1:0]  count,
  input  logic [WORD_W-1:0] ins_word,
  input  logic [WORD_W-1:0] left_entry,
  input  logic [WORD_W-1:0] key,
  input  probe_t            probe_in,
  output logic [WORD_W-1:0] entry,
  output probe_t            probe_out
);

  localparam logic [CNT_W-1:0] MY_POS = CNT_W'(CELL_IDX);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic live;
  logic match;

  // slot holds a live entry when it lies below the fill count
  assign live  = MY_POS < count;
  assign match = probe_in.active && !probe_in.hit && live && (entry == key);

  // insert: take the new word at the position, the left neighbor's word behind it
  always_ff @(posedge clk) begin
    if (ins_en) begin
      if (MY_POS == ins_pos) begin
        entry <= ins_word;
      end else if (MY_POS > ins_pos) begin
        entry <= left_entry;
      end
    end
  end

  // search token moves one cell per cycle; first live match marks it
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.active <= 1'b0;
    end else begin
      probe_out.active <= probe_in.active;
    end
    if (match) begin
      probe_out.hit <= 1'b1;
      probe_out.idx <= MY_IDX;
    end else begin
      probe_out.hit <= probe_in.hit;
      probe_out.idx <= probe_in.idx;
    end
  end

endmodule

// ----- hdl/olif_out_fifo.sv -----
// olif_out_fifo: two-entry result queue between the list core and the output channel
// depends on olif_pkg

module olif_out_fifo import olif_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  result_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign full      = fill == 2'd2;
  assign out_valid = fill != 2'd0;
  assign out_data  = slots[rd_ptr];

  // result storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- hdl/ordered_list_insert_find_unit.sv -----
// Ordered list of up to LIST_DEPTH signed words held in a chain of cells, one
// entry per cell. Insert, clear and the unused mode finish in the cycle of the
// transfer and their result is queued at once: one item per cycle while the
// result queue has room. A find sends a search token down the chain one cell
// per cycle and holds off new items until the token has left the last cell.
// Results pass through a two-entry queue, so a new item is taken while a
// result still waits on the output side. Entries need no clearing after reset.
// depends on olif_pkg, olif_cell, olif_out_fifo

module ordered_list_insert_find_unit import olif_pkg::*; #(
  parameter int unsigned LIST_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               mode,
  input  logic [POS_W-1:0]         position,
  input  logic signed [WORD_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic                     found,
  output logic [IDX_W-1:0]         found_index,
  output logic [LEN_W-1:0]         length
);

  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [WORD_W-1:0] key;
  logic              start;
  logic              take;
  logic              ins_en;
  logic              push;
  logic              fifo_full;
  result_t           res;
  result_t           out_res;
  probe_t            probe [LIST_DEPTH+1];
  logic [WORD_W-1:0] ent [LIST_DEPTH];

  assign take = in_valid && in_ready;

  // sequencer: idle takes items, search waits for the token to leave the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      start <= 1'b0;
      count <= '0;
    end else begin
      state <= state_next;
      start <= take && (mode == MODE_FIND);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      key <= value;
    end
  end

  // next state, list length and result for each item
  always_comb begin
    state_next = state;
    count_next = count;
    ins_en     = 1'b0;
    push       = 1'b0;
    in_ready   = 1'b0;
    res        = '{status: STAT_DONE, found: 1'b0, found_index: '0, length: '0};
    case (state)
      S_IDLE: begin
        in_ready = !fifo_full;
        if (take) begin
          case (mode)
            MODE_INSERT: begin
              push = 1'b1;
              if (CMP_W'(position) > CMP_W'(count)) begin
                res.status = STAT_BAD_POS;
              end else if (count == DEPTH_CNT) begin
                res.status = STAT_FULL;
              end else begin
                ins_en     = 1'b1;
                count_next = count + 1'b1;
              end
            end
            MODE_FIND: begin
              state_next = S_SEARCH;
            end
            MODE_CLEAR: begin
              push       = 1'b1;
              count_next = '0;
            end
            default: begin
              push = 1'b1;
            end
          endcase
        end
      end
      S_SEARCH: begin
        if (probe[LIST_DEPTH].active) begin
          push            = 1'b1;
          res.found       = probe[LIST_DEPTH].hit;
          res.found_index = probe[LIST_DEPTH].hit ? probe[LIST_DEPTH].idx : '0;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    res.length = LEN_W'(count_next);
  end

  // token enters the head of the chain the cycle after a find transfer
  assign probe[0] = '{active: start, hit: 1'b0, idx: '0};

  // chain of list cells
  for (genvar k = 0; k < LIST_DEPTH; k++) begin : g_cell
    logic [WORD_W-1:0] left;
    if (k == 0) begin : g_head
      assign left = value;
    end else begin : g_body
      assign left = ent[k-1];
    end
    olif_cell #(
      .CNT_W    (CNT_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ins_en     (ins_en),
      .ins_pos    (CNT_W'(position)),
      .count      (count),
      .ins_word   (value),
      .left_entry (left),
      .key        (key),
      .probe_in   (probe[k]),
      .entry      (ent[k]),
      .probe_out  (probe[k+1])
    );
  end

  // result queue toward the output channel
  olif_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .full      (fifo_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign status      = out_res.status;
  assign found       = out_res.found;
  assign found_index = out_res.found_index;
  assign length      = out_res.length;

endmodule

// ----- test/ordered_list_insert_find_unit_tb.sv -----
// ordered_list_insert_find_unit_tb: self-checking testbench for the ordered list unit
// directed and random insert / find / clear traffic with bursty input and output stalls
// depends on olif_pkg and ordered_list_insert_find_unit

`timescale 1ns / 1ps

module ordered_list_insert_find_unit_tb import olif_pkg::*; ();

  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned RANDOM_ITEMS = 1700;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = LIST_DEPTH + 4;

  typedef struct {
    logic [1:0]        mode;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
  } list_cmd_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               mode = MODE_INSERT;
  logic [POS_W-1:0]         position = '0;
  logic signed [WORD_W-1:0] value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [1:0]               status;
  logic                     found;
  logic [IDX_W-1:0]         found_index;
  logic [LEN_W-1:0]         length;

  // commands waiting to be driven and results waiting to arrive
  list_cmd_t pending_cmds[$];
  result_t   expected_results[$];

  // predicted list contents
  logic [WORD_W-1:0] model_words[LIST_DEPTH];
  int unsigned       model_len = 0;

  // stimulus-side view of the list, used only to shape commands
  int unsigned       gen_len = 0;
  logic [WORD_W-1:0] gen_pool[$];

  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  logic [15:0] rx_cycle = '0;
  list_cmd_t   drv_cmd;
  list_cmd_t   seen_cmd;
  result_t     want;

  ordered_list_insert_find_unit #(
    .LIST_DEPTH(LIST_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .position(position),
    .value(value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .found(found),
    .found_index(found_index),
    .length(length)
  );

  always #5 clk = ~clk;

  // apply one command to the predicted list and return its result
  function automatic result_t apply_list_cmd(input list_cmd_t c);
    result_t     r;
    int unsigned k;
    r = '0;
    case (c.mode)
      MODE_INSERT: begin
        if (c.pos > model_len) begin
          r.status = STAT_BAD_POS;
        end else if (model_len >= LIST_DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          for (k = model_len; k > c.pos; k--) model_words[k] = model_words[k-1];
          model_words[c.pos] = c.word;
          model_len++;
        end
      end
      MODE_FIND: begin
        for (k = 0; k < model_len; k++) begin
          if (!r.found && model_words[k] == c.word) begin
            r.found = 1'b1;
            r.found_index = k[IDX_W-1:0];
          end
        end
      end
      MODE_CLEAR: begin
        model_len = 0;
      end
      default: ;
    endcase
    r.length = model_len[LEN_W-1:0];
    return r;
  endfunction

  // queue a command and track the list length it leads to
  task automatic queue_cmd(input logic [1:0] m, input int unsigned p, input logic [WORD_W-1:0] w);
    list_cmd_t c;
    c.mode = m;
    c.pos = p[POS_W-1:0];
    c.word = w;
    pending_cmds.push_back(c);
    if (m == MODE_INSERT && p <= gen_len && gen_len < LIST_DEPTH) begin
      gen_len++;
      gen_pool.push_back(w);
    end else if (m == MODE_CLEAR) begin
      gen_len = 0;
      gen_pool.delete();
    end
  endtask

  // random word biased toward extremes and small values that repeat
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2, 3: return 32'($urandom_range(0, 7)) - 32'd3;
      default: return $urandom();
    endcase
  endfunction

  // stimulus and end of run
  initial begin
    int unsigned n;
    int unsigned r;
    logic [WORD_W-1:0] w;

    // directed: empty list cases
    queue_cmd(MODE_FIND, 0, 32'd0);
    queue_cmd(MODE_INSERT, 1, 32'd5);
    queue_cmd(MODE_CLEAR, 0, 32'd0);
    queue_cmd(MODE_INSERT, 0, 32'h8000_0000);
    queue_cmd(MODE_INSERT, 1, 32'h7fff_ffff);
    // duplicate at the head, find must report the first occurrence
    queue_cmd(MODE_INSERT, 0, 32'h7fff_ffff);
    queue_cmd(MODE_FIND, 31, 32'h7fff_ffff);
    queue_cmd(MODE_FIND, 0, 32'h8000_0000);
    queue_cmd(MODE_FIND, 0, 32'hffff_ffff);
    // unused mode leaves the list alone
    queue_cmd(2'd3, 31, 32'hffff_ffff);
    // fill to full, with one insert in the middle
    for (n = 0; n < 12; n++) queue_cmd(MODE_INSERT, gen_len, 32'h1000 + n);
    queue_cmd(MODE_INSERT, 7, 32'hffff_ffff);
    queue_cmd(MODE_INSERT, 16, 32'd9);
    // bad position wins over full
    queue_cmd(MODE_INSERT, 31, 32'd9);
    queue_cmd(MODE_FIND, 0, 32'h100b);
    queue_cmd(MODE_CLEAR, 0, 32'd0);

    // random: mostly legal inserts and finds of stored values
    n = 0;
    while (n < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        queue_cmd(MODE_INSERT, $urandom_range(0, gen_len), pick_word());
      end else if (r < 80) begin
        if (gen_pool.size() > 0 && $urandom_range(0, 9) < 7)
          w = gen_pool[$urandom_range(0, gen_pool.size() - 1)];
        else
          w = pick_word();
        queue_cmd(MODE_FIND, $urandom_range(0, 31), w);
      end else if (r < 84) begin
        if (gen_len == LIST_DEPTH || $urandom_range(0, 9) < 3)
          queue_cmd(MODE_CLEAR, $urandom_range(0, 31), pick_word());
        else
          queue_cmd(MODE_FIND, 0, pick_word());
      end else if (r < 90) begin
        if (gen_len < 31)
          queue_cmd(MODE_INSERT, $urandom_range(gen_len + 1, 31), pick_word());
        else
          queue_cmd(MODE_INSERT, 31, pick_word());
      end else if (r < 94) begin
        queue_cmd(2'd3, $urandom_range(0, 31), $urandom());
        n--;
      end else begin
        w = $urandom();
        queue_cmd(2'($urandom_range(0, 2)), $urandom_range(0, 31), w);
      end
      n++;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while ((pending_cmds.size() != 0 || in_valid || expected_results.size() != 0) &&
           idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);

    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (fail_count == 0) begin
        $display("SUCCESS");
      end else begin
        $display("FAILURE");
      end
    end
    $finish;
  end

  // driver: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      mode <= MODE_INSERT;
      position <= '0;
      value <= '0;
    end else begin
      if (in_valid && in_ready) begin
        seen_cmd.mode = mode;
        seen_cmd.pos = position;
        seen_cmd.word = value;
        expected_results.push_back(apply_list_cmd(seen_cmd));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          drv_cmd = pending_cmds.pop_front();
          mode <= drv_cmd.mode;
          position <= drv_cmd.pos;
          value <= drv_cmd.word;
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 32);
            gap_left = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: output stall pattern and result check
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 16'd1;
      case (rx_cycle[9:8])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= 1'($urandom_range(0, 1));
        2'd2: out_ready <= (rx_cycle[2:0] != 3'd0);
        default: out_ready <= ($urandom_range(0, 9) < 8);
      endcase
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected: status %0d found %0d index %0d length %0d",
                 status, found, found_index, length);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            fail_count++;
          end
          if (found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found);
            fail_count++;
          end
          if (found_index !== want.found_index) begin
            $error("found_index: expected %0d, actual %0d", want.found_index, found_index);
            fail_count++;
          end
          if (length !== want.length) begin
            $error("length: expected %0d, actual %0d", want.length, length);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ----- sim.f -----
hdl/olif_pkg.sv
hdl/olif_cell.sv
hdl/olif_out_fifo.sv
hdl/ordered_list_insert_find_unit.sv
test/ordered_list_insert_find_unit_tb.sv
